// ===== hw/rtl/pss_pkg.sv =====
// Shared types, constants and helpers for the preemptive priority scheduler.
package pss_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;
	localparam int PRIO_BITS = 8;
	localparam int SLOT_W    = 4;
	localparam int REQ_W     = 2;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_TICK  = 2'd2
	} req_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_COMMIT,
		ST_SETTLE,
		ST_RESP
	} state_t;

	// best-so-far task, passed cell to cell during a scan
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     slot;
		logic [PRIO_BITS-1:0] prio;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [TIME_BITS-1:0] remaining;
	} cand_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                 clear;
		logic                 load;
		logic                 dec;
		logic [SLOT_W-1:0]    load_slot;
		logic [IDX_W-1:0]     dec_slot;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [PRIO_BITS-1:0] prio;
	} cell_ctl_t;

	function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
		return (t == {TIME_BITS{1'b1}}) ? t : t + TIME_BITS'(1);
	endfunction

endpackage

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Top level: request controller, task cell chain and result register.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_stall   | req_type slot arrival burst priority_req
//  out     | out_valid/out_stall | ran_valid ran_slot tick_time finished
//          |                    | finish_time turnaround waiting all_done
//
// A tick goes from accept through start, then the candidate walks the chain cell by cell,
// then commit, settle and response. Clear, load and unknown requests go from start straight
// to settle and response. The controller returns to idle before it takes the next item, so
// a new item is taken only after the last result is loaded. A result waiting in the output
// register holds the next item only once that item reaches response.
// Reset clears valid bits, time and control.
module preemptive_priority_scheduler import pss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [TIME_BITS-1:0] arrival,
	input  logic [TIME_BITS-1:0] burst,
	input  logic [PRIO_BITS-1:0] priority_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ran_valid,
	output logic [SLOT_W-1:0]    ran_slot,
	output logic [TIME_BITS-1:0] tick_time,
	output logic                 finished,
	output logic [TIME_BITS-1:0] finish_time,
	output logic [TIME_BITS-1:0] turnaround,
	output logic [TIME_BITS-1:0] waiting,
	output logic                 all_done
);

	state_t state_q, state_d;

	logic [REQ_W-1:0]     req_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [TIME_BITS-1:0] arr_in_q;
	logic [TIME_BITS-1:0] bst_in_q;
	logic [PRIO_BITS-1:0] prio_in_q;

	logic [TIME_BITS-1:0] now_q;
	logic [IDX_W-1:0]     cnt_q;

	logic                 ran_valid_q;
	logic [SLOT_W-1:0]    ran_slot_q;
	logic [TIME_BITS-1:0] tick_q;
	logic                 fin_q;
	logic [TIME_BITS-1:0] ftime_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] bst_q;
	logic [TIME_BITS-1:0] tat_q;
	logic                 all_done_q;

	logic                 out_valid_q;
	logic                 ran_valid_o_q;
	logic [SLOT_W-1:0]    ran_slot_o_q;
	logic [TIME_BITS-1:0] tick_o_q;
	logic                 fin_o_q;
	logic [TIME_BITS-1:0] ftime_o_q;
	logic [TIME_BITS-1:0] tat_o_q;
	logic [TIME_BITS-1:0] wait_o_q;
	logic                 all_done_o_q;

	logic                 accept;
	logic                 out_load;
	logic                 scan_end;
	cell_ctl_t            ctl;
	cand_t                chain [MAX_TASKS+1];
	cand_t                winner;
	logic [MAX_TASKS-1:0] busy;
	logic [TIME_BITS-1:0] next_time;

	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || !out_stall);
	assign scan_end  = (cnt_q == IDX_W'(MAX_TASKS - 1));
	assign winner    = chain[MAX_TASKS];
	assign next_time = sat_inc(now_q);

	// cell chain
	assign chain[0] = '0;

	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		pss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(k)),
			.ctl      (ctl),
			.now      (now_q),
			.cand_in  (chain[k]),
			.cand_out (chain[k+1]),
			.busy     (busy[k])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_EXEC;
			ST_EXEC:   state_d = (req_q == REQ_TICK) ? ST_SCAN : ST_SETTLE;
			ST_SCAN:   if (scan_end) state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_SETTLE;
			ST_SETTLE: state_d = ST_RESP;
			ST_RESP:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall      = 1'b1;
		ctl.clear     = 1'b0;
		ctl.load      = 1'b0;
		ctl.dec       = 1'b0;
		ctl.load_slot = slot_q;
		ctl.dec_slot  = winner.slot;
		ctl.arrival   = arr_in_q;
		ctl.burst     = bst_in_q;
		ctl.prio      = prio_in_q;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_EXEC: begin
				ctl.clear = (req_q == REQ_CLEAR);
				ctl.load  = (req_q == REQ_LOAD);
			end
			ST_COMMIT: ctl.dec = winner.found;
			ST_SCAN, ST_SETTLE, ST_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_EXEC) && (req_q == REQ_CLEAR))
				now_q <= '0;
			else if (state_q == ST_COMMIT)
				now_q <= next_time;
			if (state_q == ST_SCAN)
				cnt_q <= scan_end ? '0 : cnt_q + IDX_W'(1);
		end
	end

	// request and per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			slot_q    <= slot;
			arr_in_q  <= arrival;
			bst_in_q  <= burst;
			prio_in_q <= priority_req;
		end
		case (state_q)
			ST_EXEC: begin
				tick_q      <= (req_q == REQ_CLEAR) ? '0 : now_q;
				ran_valid_q <= 1'b0;
				ran_slot_q  <= '0;
				fin_q       <= 1'b0;
			end
			ST_COMMIT: begin
				ran_valid_q <= winner.found;
				ran_slot_q  <= winner.found ? SLOT_W'(winner.slot) : '0;
				fin_q       <= winner.found && (winner.remaining == TIME_BITS'(1));
				ftime_q     <= next_time;
				arr_q       <= winner.arrival;
				bst_q       <= winner.burst;
			end
			ST_SETTLE: begin
				tat_q      <= ftime_q - arr_q;
				all_done_q <= ~|busy;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ran_valid_o_q <= ran_valid_q;
			ran_slot_o_q  <= ran_slot_q;
			tick_o_q      <= tick_q;
			fin_o_q       <= fin_q;
			ftime_o_q     <= fin_q ? ftime_q : '0;
			tat_o_q       <= fin_q ? tat_q : '0;
			// saturated time can make turnaround shorter than the burst
			wait_o_q      <= (fin_q && (tat_q >= bst_q)) ? tat_q - bst_q : '0;
			all_done_o_q  <= all_done_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ran_valid   = ran_valid_o_q;
	assign ran_slot    = ran_slot_o_q;
	assign tick_time   = tick_o_q;
	assign finished    = fin_o_q;
	assign finish_time = ftime_o_q;
	assign turnaround  = tat_o_q;
	assign waiting     = wait_o_q;
	assign all_done    = all_done_o_q;

	// time only moves on commit or clear
	a_time_stable_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> $stable(now_q))
		else $error("time changed during scan");

	// a chosen task always has work left
	a_winner_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_COMMIT) && winner.found) |-> (winner.remaining != '0))
		else $error("winner has no remaining work");

	// a finish is only reported for a task that ran
	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!fin_q || ran_valid_q))
		else $error("finish without a running task");

	// a cleared table is always done
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESP) && (req_q == REQ_CLEAR)) |-> all_done_q)
		else $error("all_done low after clear");

endmodule

// ===== hw/rtl/pss_cell.sv =====
// One task slot of the scheduler chain: holds a task and forwards the better candidate.
module pss_cell import pss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     idx,
	input  cell_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] now,
	input  cand_t                cand_in,
	output cand_t                cand_out,
	output logic                 busy
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] arrival_q;
	logic [TIME_BITS-1:0] burst_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [TIME_BITS-1:0] rem_q;
	cand_t                cand_q;

	logic load_hit;
	logic dec_hit;
	logic elig;
	logic take;
	cand_t own;

	assign load_hit = ctl.load && (CMP_W'(ctl.load_slot) == CMP_W'(idx));
	assign dec_hit  = ctl.dec && (ctl.dec_slot == idx);
	assign busy     = valid_q && (rem_q != '0);
	assign elig     = busy && (arrival_q <= now);

	// lower priority number wins, then earlier arrival; equal keeps the lower slot
	always_comb begin
		take = 1'b0;
		if (elig) begin
			if (!cand_in.found)
				take = 1'b1;
			else if (prio_q < cand_in.prio)
				take = 1'b1;
			else if ((prio_q == cand_in.prio) && (arrival_q < cand_in.arrival))
				take = 1'b1;
		end
	end

	always_comb begin
		own.found     = 1'b1;
		own.slot      = idx;
		own.prio      = prio_q;
		own.arrival   = arrival_q;
		own.burst     = burst_q;
		own.remaining = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (load_hit) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			arrival_q <= ctl.arrival;
			burst_q   <= ctl.burst;
			prio_q    <= ctl.prio;
			rem_q     <= ctl.burst;
		end else if (dec_hit) begin
			rem_q <= rem_q - TIME_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= take ? own : cand_in;
	end

	assign cand_out = cand_q;

endmodule
